FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CEF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define CEF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

FILE: hw/rtl/cef_pkg.sv
`timescale 1ns / 1ps

package cef_pkg;

   localparam int unsigned CntW      = 64;
   localparam int unsigned CoreW     = 6;
   localparam int unsigned StatusW   = 2;
   localparam int unsigned NomW      = 24;
   localparam int unsigned CoreCntW  = 7;
   localparam int unsigned CsrIdxW   = 2;
   localparam int unsigned CsrDataW  = 24;
   localparam int unsigned QueueDepth = 2;

   // Register indexes on the configuration channel.
   localparam logic [CsrIdxW-1:0] CSR_NOMINAL_FREQ  = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CORE_COUNT    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_BLOCK_ENABLED = 2'd2;

   // Result status codes.
   localparam logic [StatusW-1:0] ST_OK       = 2'd0;
   localparam logic [StatusW-1:0] ST_NOT_INIT = 2'd1;
   localparam logic [StatusW-1:0] ST_BAD_CORE = 2'd2;
   localparam logic [StatusW-1:0] ST_ZERO_REF = 2'd3;

   // Item function codes.
   localparam logic FUNC_SNAP = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Percent scale, and the largest actual delta that survives the x100 scaling.
   localparam logic [CntW-1:0] PctScale   = 64'd100;
   localparam logic [CntW-1:0] SatLimit   = 64'd184467440737095516;
   localparam int unsigned     ScaleShift = 7;

   // The final divide by 100 retires one hex digit per cycle.
   localparam int unsigned DigitW     = 4;
   localparam int unsigned ScaleSteps = CntW / DigitW;

   typedef struct packed {
      logic [NomW-1:0]     nominal_freq;
      logic [CoreCntW-1:0] core_count;
      logic                block_enabled;
   } cfg_type;

   typedef enum logic [2:0] {
      JOB_DISABLED,
      JOB_BAD_CORE,
      JOB_SNAP,
      JOB_READ,
      JOB_ZERO_REF,
      JOB_COMPUTE
   } job_kind_type;

   typedef struct packed {
      job_kind_type    kind;
      logic [CntW-1:0] delta_actual;
      logic [CntW-1:0] delta_reference;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_START,
      BK_DIVIDE,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_SUM,
      BK_SCALE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic            start;
      logic [CntW-1:0] dividend;
      logic [CntW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [CntW-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/cef_ifs.sv
`timescale 1ns / 1ps

interface cef_req_if;
   import cef_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [CoreW-1:0]    core;
   logic [CntW-1:0]     actual_count;
   logic [CntW-1:0]     reference_count;

   modport source (output valid, func, core, actual_count, reference_count, input ready);
   modport sink (input valid, func, core, actual_count, reference_count, output ready);
endinterface

interface cef_rsp_if;
   import cef_pkg::*;
   logic                valid;
   logic                ready;
   logic [CntW-1:0]     freq_out;
   logic [StatusW-1:0]  status;

   modport source (output valid, freq_out, status, input ready);
   modport sink (input valid, freq_out, status, output ready);
endinterface

interface cef_csr_if;
   import cef_pkg::*;
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/core_effective_frequency_core.sv
`timescale 1ns / 1ps

// Effective core frequency from per-core actual and reference cycle counters. A snap item
// stores the counter pair as that core's baseline and answers status 0 with frequency 0; a
// read item takes the wrapping deltas against the stored baseline, replaces it, and answers
// nominal_freq * (100 * actual / reference) / 100, with the deltas shifted right by 7 first
// when the actual delta is too large to scale by 100. Disabled, bad-core and zero-reference
// items answer status 1, 2 and 3 with frequency 0. A core must be snapped before it is read.
// A read item passes through the bit-serial percent divider and then a divide by 100 that
// retires one hex digit at a time; snap and error items skip both and go straight to the
// result register. The front end can accept a new item every cycle until its two-entry
// queue fills, so results are returned in order at the pace of the divider.
// Configuration writes are always ready and take effect at once; write them only while no
// item is in flight. The baseline store needs no clearing after reset.
module core_effective_frequency_core #(
   parameter int unsigned MAX_CORES = 64
) (
   input  logic      clock,
   input  logic      reset,
   cef_req_if.sink   req_in,
   cef_rsp_if.source rsp_out,
   cef_csr_if.sink   csr_in
);
   import cef_pkg::*;

   cfg_type cfg_ff;
   logic    csr_fire;

   job_type front_job, queue_job;
   logic    front_valid, queue_ready;
   logic    queue_valid, queue_pop;

   // Configuration registers. Writes to an index past the list are dropped.
   assign csr_in.ready = 1'b1;
   assign csr_fire     = csr_in.valid && csr_in.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nominal_freq  <= '0;
         cfg_ff.core_count    <= CoreCntW'(1);
         cfg_ff.block_enabled <= 1'b0;
      end else if (csr_fire) begin
         unique case (csr_in.index)
            CSR_NOMINAL_FREQ:  cfg_ff.nominal_freq  <= csr_in.data[NomW-1:0];
            CSR_CORE_COUNT:    cfg_ff.core_count    <= csr_in.data[CoreCntW-1:0];
            CSR_BLOCK_ENABLED: cfg_ff.block_enabled <= csr_in.data[0];
            default:           cfg_ff.block_enabled <= cfg_ff.block_enabled;
         endcase
      end
   end

   // The front end classifies each item, swaps the core's baseline and forms the deltas.
   cef_front #(
      .MAX_CORES (MAX_CORES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_in),
      .job       (front_job),
      .job_valid (front_valid),
      .job_ready (queue_ready)
   );

   // A short queue lets the front end keep taking items while the back end divides.
   cef_fifo #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_data  (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_pop),
      .pop_data   (queue_job)
   );

   // The back end runs the percent divide, the nominal scaling and the result register.
   cef_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job       (queue_job),
      .job_valid (queue_valid),
      .job_pop   (queue_pop),
      .rsp       (rsp_out)
   );

endmodule

FILE: hw/rtl/cef_front.sv
`timescale 1ns / 1ps

module cef_front #(
   parameter int unsigned MAX_CORES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  cef_pkg::cfg_type cfg,
   cef_req_if.sink          req,
   output cef_pkg::job_type job,
   output logic             job_valid,
   input  logic             job_ready
);
   import cef_pkg::*;

   localparam int unsigned AddrW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

   logic [CntW-1:0] mem_act [MAX_CORES];
   logic [CntW-1:0] mem_ref [MAX_CORES];

   logic             req_fire;
   logic [AddrW-1:0] addr;
   logic             core_bad;
   job_kind_type     kind;

   logic            stg_valid_ff, stg_valid_in;
   job_kind_type    stg_kind_ff;
   logic [CntW-1:0] stg_act_ff, stg_ref_ff;
   logic [CntW-1:0] old_act_ff, old_ref_ff;

   logic [CntW-1:0] delta_act, delta_ref;
   logic            big;
   logic [CntW-1:0] scaled_act, scaled_ref;

   assign req_fire = req.valid && req.ready;
   assign req.ready = !stg_valid_ff || job_ready;
   assign addr = AddrW'(req.core);

   always_comb begin
      core_bad = ({1'b0, req.core} >= cfg.core_count) || (32'(req.core) >= MAX_CORES);
      priority if (!cfg.block_enabled) begin
         kind = JOB_DISABLED;
      end else if (core_bad) begin
         kind = JOB_BAD_CORE;
      end else if (req.func == FUNC_SNAP) begin
         kind = JOB_SNAP;
      end else begin
         kind = JOB_READ;
      end
   end

   // The baseline is read and replaced at the same edge, so the read sees the old pair.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         old_act_ff <= mem_act[addr];
         old_ref_ff <= mem_ref[addr];
         if (kind == JOB_SNAP || kind == JOB_READ) begin
            mem_act[addr] <= req.actual_count;
            mem_ref[addr] <= req.reference_count;
         end
      end
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_fire) begin
         stg_valid_in = 1'b1;
      end else if (job_ready) begin
         stg_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_kind_ff <= kind;
         stg_act_ff  <= req.actual_count;
         stg_ref_ff  <= req.reference_count;
      end
   end

   always_comb begin
      delta_act  = stg_act_ff - old_act_ff;
      delta_ref  = stg_ref_ff - old_ref_ff;
      big        = delta_act > SatLimit;
      scaled_act = big ? (delta_act >> ScaleShift) : delta_act;
      scaled_ref = big ? (delta_ref >> ScaleShift) : delta_ref;

      job.kind            = stg_kind_ff;
      job.delta_actual    = scaled_act;
      job.delta_reference = scaled_ref;
      if (stg_kind_ff == JOB_READ) begin
         job.kind = (scaled_ref == '0) ? JOB_ZERO_REF : JOB_COMPUTE;
      end
   end

   assign job_valid = stg_valid_ff;

endmodule

FILE: hw/rtl/cef_fifo.sv
`timescale 1ns / 1ps

module cef_fifo #(
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cef_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output cef_pkg::job_type pop_data
);
   import cef_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   job_type           slot_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CntW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/cef_divider.sv
`timescale 1ns / 1ps

module cef_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cef_pkg::div_req_type div_req,
   output cef_pkg::div_rsp_type div_rsp
);
   import cef_pkg::*;

   localparam int unsigned StepW = $clog2(CntW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [StepW-1:0]  step_ff;
   logic [CntW-1:0]   rem_ff, quo_ff, dvs_ff;
   logic [CntW:0]     trial;
   logic              fits;

   // Restoring division: one quotient bit per cycle, dividend bits shift out
   // of the top of the quotient register as quotient bits shift in below.
   assign trial = {rem_ff, quo_ff[CntW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = busy_ff && (step_ff == '0);
      if (div_req.start) begin
         busy_in = 1'b1;
      end else if (busy_ff && step_ff == '0) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff  <= '0;
         quo_ff  <= div_req.dividend;
         dvs_ff  <= div_req.divisor;
         step_ff <= StepW'(CntW - 1);
      end else if (busy_ff) begin
         rem_ff  <= fits ? CntW'(trial - {1'b0, dvs_ff}) : trial[CntW-1:0];
         quo_ff  <= {quo_ff[CntW-2:0], fits};
         step_ff <= step_ff - 1'b1;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: hw/rtl/cef_back.sv
`timescale 1ns / 1ps

module cef_back (
   input  logic             clock,
   input  logic             reset,
   input  cef_pkg::cfg_type cfg,
   input  cef_pkg::job_type job,
   input  logic             job_valid,
   output logic             job_pop,
   cef_rsp_if.source        rsp
);
   import cef_pkg::*;

   localparam int unsigned RemW  = $clog2(PctScale);
   localparam int unsigned XW    = RemW + DigitW;
   localparam int unsigned StepW = $clog2(ScaleSteps);
   localparam int unsigned HalfW = CntW / 2;
   localparam int unsigned LoW   = NomW + HalfW;

   function automatic logic [DigitW-1:0] hex_digit(input logic [XW-1:0] x);
      logic [DigitW-1:0] d;
      d = '0;
      for (int k = 1; k < (1 << DigitW); k++) begin
         if (x >= XW'(k * int'(PctScale))) begin
            d = DigitW'(k);
         end
      end
      return d;
   endfunction

   function automatic logic [StatusW-1:0] status_of(input job_kind_type kind);
      logic [StatusW-1:0] s;
      unique case (kind)
         JOB_DISABLED: s = ST_NOT_INIT;
         JOB_BAD_CORE: s = ST_BAD_CORE;
         JOB_ZERO_REF: s = ST_ZERO_REF;
         default:      s = ST_OK;
      endcase
      return s;
   endfunction

   back_state_type state_ff, state_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic do_pop, do_start, do_lo, do_hi, do_sum, do_scale, do_out;

   job_type            job_ff;
   logic [LoW-1:0]     prod_lo_ff;
   logic [HalfW-1:0]   prod_hi_ff;
   logic [CntW-1:0]    val_ff;
   logic [RemW-1:0]    rem_ff;
   logic [StepW-1:0]   step_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CntW-1:0]    rsp_freq_ff;
   logic [StatusW-1:0] rsp_status_ff;

   logic [XW-1:0]      x;
   logic [DigitW-1:0]  digit;
   logic               out_free;

   cef_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = (job.kind == JOB_COMPUTE) ? BK_START : BK_DONE;
            end
         end
         BK_START:  state_in = BK_DIVIDE;
         BK_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = BK_MUL_LO;
            end
         end
         BK_MUL_LO: state_in = BK_MUL_HI;
         BK_MUL_HI: state_in = BK_SUM;
         BK_SUM:    state_in = BK_SCALE;
         BK_SCALE: begin
            if (step_ff == StepW'(ScaleSteps - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      do_pop   = 1'b0;
      do_start = 1'b0;
      do_lo    = 1'b0;
      do_hi    = 1'b0;
      do_sum   = 1'b0;
      do_scale = 1'b0;
      do_out   = 1'b0;
      unique case (state_ff)
         BK_IDLE:   do_pop   = job_valid;
         BK_START:  do_start = 1'b1;
         BK_MUL_LO: do_lo    = 1'b1;
         BK_MUL_HI: do_hi    = 1'b1;
         BK_SUM:    do_sum   = 1'b1;
         BK_SCALE:  do_scale = 1'b1;
         BK_DONE:   do_out   = out_free;
         default:   do_pop   = 1'b0;
      endcase
   end

   assign job_pop = do_pop;

   // Percent dividend is delta_actual * 100, kept to 64 bits.
   assign div_req.start    = do_start;
   assign div_req.dividend = (job_ff.delta_actual << 6) + (job_ff.delta_actual << 5)
                           + (job_ff.delta_actual << 2);
   assign div_req.divisor  = job_ff.delta_reference;

   assign x     = {rem_ff, val_ff[CntW-1 -: DigitW]};
   assign digit = hex_digit(x);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         job_ff <= job;
      end
      if (do_lo) begin
         prod_lo_ff <= LoW'(cfg.nominal_freq) * LoW'(div_rsp.quotient[HalfW-1:0]);
      end
      if (do_hi) begin
         prod_hi_ff <= HalfW'(HalfW'(cfg.nominal_freq) * div_rsp.quotient[CntW-1:HalfW]);
      end
      if (do_sum) begin
         val_ff  <= CntW'(prod_lo_ff) + {prod_hi_ff, {HalfW{1'b0}}};
         rem_ff  <= '0;
         step_ff <= '0;
      end
      if (do_scale) begin
         val_ff  <= {val_ff[CntW-DigitW-1:0], digit};
         rem_ff  <= RemW'(x - XW'(int'(digit) * int'(PctScale)));
         step_ff <= step_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_out) begin
         rsp_freq_ff   <= (job_ff.kind == JOB_COMPUTE) ? val_ff : '0;
         rsp_status_ff <= status_of(job_ff.kind);
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.freq_out = rsp_freq_ff;
   assign rsp.status   = rsp_status_ff;

endmodule

FILE: hw/rtl/cef_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cef_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [cef_pkg::CntW-1:0]   freq_out,
   input logic [cef_pkg::StatusW-1:0] status
);
   import cef_pkg::*;

   logic [7:0] live_ff, live_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Items accepted whose results have not yet been taken.
   always_comb begin
      live_in = live_ff;
      if (req_fire && !rsp_fire) begin
         live_in = live_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         live_in = live_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   `CEF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(freq_out) && $stable(status), "result changed while stalled")
   `CEF_ASSERT(a_err_zero, clock, reset, rsp_valid && status != ST_OK |-> freq_out == '0, "error result carries a frequency")
   `CEF_ASSERT(a_no_orphan, clock, reset, rsp_valid |-> live_ff != '0, "result without an accepted item")
   `CEF_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

endmodule

bind core_effective_frequency_core cef_checker u_cef_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_in.valid),
   .req_ready (req_in.ready),
   .rsp_valid (rsp_out.valid),
   .rsp_ready (rsp_out.ready),
   .freq_out  (rsp_out.freq_out),
   .status    (rsp_out.status)
);
